FILE: rtl/core/i2cbm_pkg.sv
`default_nettype none
package i2cbm_pkg;

  // Command codes carried in the command field of an input transfer.
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_STOP    = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_WAITACK = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_IDLE    = 3'd7;

  // Kind of an input item.
  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_BIT_DELAY = 2'd0;
  localparam logic [1:0] REG_STOP_HOLD = 2'd1;
  localparam logic [1:0] REG_ACK_TMO   = 2'd2;

  localparam logic [7:0] BIT_DELAY_RST = 8'd2;
  localparam logic [7:0] STOP_HOLD_RST = 8'd1;
  localparam logic [7:0] ACK_TMO_RST   = 8'd250;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  // A programmed delay of zero ticks lasts one tick.
  function automatic logic [7:0] delay_load(input logic [7:0] t);
    return (t == 8'd0) ? 8'd1 : t;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/i2c_bit_level_master.sv
// I2C bit-level master driven by a stream of items.
// Input channel (in_*): each transfer is a command (in_tuser = 0) or one delay
// tick (in_tuser = 1) carrying the sampled SDA level. Commands are start, stop,
// write byte, wait for acknowledge and read byte; a command that arrives while
// another is running is dropped. Ticks while idle change nothing.
// Output channel (out_*): exactly one result transfer per input transfer,
// giving the SCL/SDA drive levels, busy and done flags, the last read byte and
// the missing-acknowledge flag as they stand after that item.
// The result is registered on the edge that accepts the item and shows on
// out_tvalid in the next cycle. One item is accepted every cycle unless a
// result is stalled; the state update is a single pass of logic from the item
// and the sequencer registers into the result register.
// When the receiver stalls, the result register holds and in_tready drops
// until that result is taken; accepting resumes in the cycle it is taken.
// Configuration (cfg_*) is always ready and should be written while idle.
// Synchronous reset (rst_n low) returns the sequencer to idle with SCL high,
// SDA high and driven, the delay registers to 2, 1 and 250, and empties the
// result register.
`default_nettype none
module i2c_bit_level_master (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [2:0] command, [10:3] tx_byte, [11] ack_after_read, [12] sda_in, rest 0.
  input  wire logic [i2cbm_pkg::IN_W-1:0]   in_tdata,
  // [0] kind
  input  wire logic                         in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_missing, rest 0.
  output logic [i2cbm_pkg::OUT_W-1:0]       out_tdata,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [7:0]                   cfg_data
);

  logic [7:0] bit_delay_r, stop_hold_r, ack_tmo_r;

  logic [2:0] active_r, active_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] delay_r, delay_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       rd_ack_r, rd_ack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       drv_r, drv_nxt;
  logic       ack_miss_r, ack_miss_nxt;
  logic [7:0] rx_hold_r, rx_hold_nxt;
  logic       done_nxt;

  logic                       out_valid_r;
  logic [i2cbm_pkg::OUT_W-1:0] out_data_r;

  logic       in_fire;
  logic [2:0] in_cmd;
  logic [7:0] in_tx;
  logic       in_ack;
  logic       in_sda;

  assign in_cmd = in_tdata[2:0];
  assign in_tx  = in_tdata[10:3];
  assign in_ack = in_tdata[11];
  assign in_sda = in_tdata[12];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  always_comb begin
    logic       adv;
    logic [7:0] dec;
    logic [3:0] bc_inc;
    active_nxt   = active_r;
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    delay_nxt    = delay_r;
    poll_nxt     = poll_r;
    shift_nxt    = shift_r;
    rd_ack_nxt   = rd_ack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    drv_nxt      = drv_r;
    ack_miss_nxt = ack_miss_r;
    rx_hold_nxt  = rx_hold_r;
    done_nxt     = 1'b0;
    adv          = 1'b0;
    dec          = (delay_r != 8'd0) ? delay_r - 8'd1 : 8'd0;
    bc_inc       = bit_cnt_r + 4'd1;

    if (in_tuser == i2cbm_pkg::KIND_COMMAND) begin
      if (active_r == i2cbm_pkg::CMD_IDLE && in_cmd <= i2cbm_pkg::CMD_READ) begin
        active_nxt  = in_cmd;
        bit_cnt_nxt = 4'd0;
        poll_nxt    = 8'd0;
        phase_nxt   = 3'd1;
        delay_nxt   = i2cbm_pkg::delay_load(bit_delay_r);
        case (in_cmd)
          i2cbm_pkg::CMD_START: begin
            drv_nxt = 1'b1;
            scl_nxt = 1'b1;
          end
          i2cbm_pkg::CMD_STOP: begin
            drv_nxt = 1'b1;
            sda_nxt = 1'b0;
            scl_nxt = 1'b0;
          end
          i2cbm_pkg::CMD_WRITE: begin
            drv_nxt   = 1'b1;
            scl_nxt   = 1'b0;
            sda_nxt   = in_tx[7];
            shift_nxt = {in_tx[6:0], 1'b0};
          end
          i2cbm_pkg::CMD_WAITACK: begin
            drv_nxt      = 1'b0;
            sda_nxt      = 1'b1;
            ack_miss_nxt = 1'b0;
          end
          default: begin
            drv_nxt    = 1'b0;
            rd_ack_nxt = in_ack;
            shift_nxt  = 8'd0;
            scl_nxt    = 1'b0;
          end
        endcase
      end
    end else if (active_r != i2cbm_pkg::CMD_IDLE) begin
      // Polling in wait-ack runs every tick; everything else waits out a delay.
      if (active_r == i2cbm_pkg::CMD_WAITACK && phase_r == 3'd2) begin
        adv = 1'b1;
      end else begin
        delay_nxt = dec;
        adv       = (dec == 8'd0);
      end
      if (adv) begin
        case (active_r)
          i2cbm_pkg::CMD_START: begin
            if (phase_r == 3'd1) begin
              sda_nxt   = 1'b1;
              delay_nxt = i2cbm_pkg::delay_load(bit_delay_r);
              phase_nxt = 3'd2;
            end else if (phase_r == 3'd2) begin
              sda_nxt   = 1'b0;
              delay_nxt = i2cbm_pkg::delay_load(bit_delay_r);
              phase_nxt = 3'd3;
            end else begin
              scl_nxt  = 1'b0;
              done_nxt = 1'b1;
            end
          end
          i2cbm_pkg::CMD_STOP: begin
            if (phase_r == 3'd1) begin
              scl_nxt   = 1'b1;
              delay_nxt = i2cbm_pkg::delay_load(stop_hold_r);
              phase_nxt = 3'd2;
            end else begin
              sda_nxt  = 1'b1;
              done_nxt = 1'b1;
            end
          end
          i2cbm_pkg::CMD_WRITE: begin
            if (phase_r == 3'd1) begin
              scl_nxt   = 1'b1;
              delay_nxt = i2cbm_pkg::delay_load(bit_delay_r);
              phase_nxt = 3'd2;
            end else begin
              bit_cnt_nxt = bc_inc;
              if (bc_inc >= 4'd8) begin
                scl_nxt  = 1'b0;
                done_nxt = 1'b1;
              end else begin
                scl_nxt   = 1'b0;
                sda_nxt   = shift_r[7];
                shift_nxt = {shift_r[6:0], 1'b0};
                delay_nxt = i2cbm_pkg::delay_load(bit_delay_r);
                phase_nxt = 3'd1;
              end
            end
          end
          i2cbm_pkg::CMD_WAITACK: begin
            if (phase_r == 3'd1) begin
              scl_nxt   = 1'b1;
              delay_nxt = i2cbm_pkg::delay_load(bit_delay_r);
              phase_nxt = 3'd2;
            end else if (phase_r == 3'd2) begin
              if (!in_sda) begin
                scl_nxt  = 1'b0;
                done_nxt = 1'b1;
              end else if (poll_r >= ack_tmo_r) begin
                // No acknowledge: release the bus with a stop condition.
                drv_nxt   = 1'b1;
                sda_nxt   = 1'b0;
                scl_nxt   = 1'b0;
                delay_nxt = i2cbm_pkg::delay_load(bit_delay_r);
                phase_nxt = 3'd3;
              end else begin
                poll_nxt = poll_r + 8'd1;
              end
            end else if (phase_r == 3'd3) begin
              scl_nxt   = 1'b1;
              delay_nxt = i2cbm_pkg::delay_load(stop_hold_r);
              phase_nxt = 3'd4;
            end else begin
              sda_nxt      = 1'b1;
              ack_miss_nxt = 1'b1;
              done_nxt     = 1'b1;
            end
          end
          default: begin
            if (phase_r == 3'd1) begin
              scl_nxt   = 1'b1;
              shift_nxt = {shift_r[6:0], in_sda};
              delay_nxt = i2cbm_pkg::delay_load(bit_delay_r);
              phase_nxt = 3'd2;
            end else if (phase_r == 3'd2) begin
              bit_cnt_nxt = bc_inc;
              scl_nxt     = 1'b0;
              delay_nxt   = i2cbm_pkg::delay_load(bit_delay_r);
              if (bc_inc < 4'd8) begin
                phase_nxt = 3'd1;
              end else begin
                rx_hold_nxt = shift_r;
                drv_nxt     = 1'b1;
                sda_nxt     = !rd_ack_r;
                phase_nxt   = 3'd3;
              end
            end else if (phase_r == 3'd3) begin
              scl_nxt   = 1'b1;
              delay_nxt = i2cbm_pkg::delay_load(bit_delay_r);
              phase_nxt = 3'd4;
            end else begin
              scl_nxt  = 1'b0;
              done_nxt = 1'b1;
            end
          end
        endcase
      end
      if (done_nxt) begin
        active_nxt = i2cbm_pkg::CMD_IDLE;
        phase_nxt  = 3'd0;
        delay_nxt  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_delay_r <= i2cbm_pkg::BIT_DELAY_RST;
      stop_hold_r <= i2cbm_pkg::STOP_HOLD_RST;
      ack_tmo_r   <= i2cbm_pkg::ACK_TMO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cbm_pkg::REG_BIT_DELAY: bit_delay_r <= cfg_data;
        i2cbm_pkg::REG_STOP_HOLD: stop_hold_r <= cfg_data;
        i2cbm_pkg::REG_ACK_TMO:   ack_tmo_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= i2cbm_pkg::CMD_IDLE;
      phase_r     <= 3'd0;
      bit_cnt_r   <= 4'd0;
      delay_r     <= 8'd0;
      poll_r      <= 8'd0;
      shift_r     <= 8'd0;
      rd_ack_r    <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drv_r       <= 1'b1;
      ack_miss_r  <= 1'b0;
      rx_hold_r   <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        active_r    <= active_nxt;
        phase_r     <= phase_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        delay_r     <= delay_nxt;
        poll_r      <= poll_nxt;
        shift_r     <= shift_nxt;
        rd_ack_r    <= rd_ack_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        drv_r       <= drv_nxt;
        ack_miss_r  <= ack_miss_nxt;
        rx_hold_r   <= rx_hold_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {2'b00, ack_miss_nxt, rx_hold_nxt, done_nxt,
                     (active_nxt != i2cbm_pkg::CMD_IDLE), drv_nxt, sda_nxt, scl_nxt};
    end
  end

`ifndef SYNTHESIS
  // A completing item always leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[3])
    else $error("done result reports busy");

  // Idle and phase zero go together.
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r == i2cbm_pkg::CMD_IDLE) == (phase_r == 3'd0))
    else $error("phase out of step with active command");

  // A stalled result blocks new input and is kept unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Wait-ack polling never runs past the timeout.
  a_poll_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r == i2cbm_pkg::CMD_WAITACK && phase_r == 3'd2 |-> poll_r <= ack_tmo_r)
    else $error("poll count beyond timeout");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ROUNDS = 3;
  localparam int ROUND_ITEMS = 24;
  localparam int SCRIPT_LEN = 19;

  // Codes outside the command set; the block must ignore them.
  localparam logic [2:0] CMD_UNDEF_LO  = 3'd5;
  localparam logic [2:0] CMD_UNDEF_MID = 3'd6;
  // Index with no register behind it.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic       am;
    logic [7:0] rx;
    logic       done;
    logic       busy;
    logic       drv;
    logic       sda;
    logic       scl;
  } line_result_t;

  typedef struct {
    line_result_t res;
    realtime      accept_ns;
  } pending_t;

  // How the SDA samples look on the ticks that run a command to its end.
  typedef enum {RUN_NONE, RUN_LOW, RUN_HIGH, RUN_RANDOM, RUN_MIX} run_mode_t;

  typedef struct {
    logic       kind;
    logic [2:0] cmd;
    logic [7:0] tx;
    logic       ack;
    logic       sda;
    run_mode_t  after;
    bit         pin;
    line_result_t want;
  } script_row_t;

  localparam line_result_t LINES_IDLE =
    '{am: 1'b0, rx: 8'h00, done: 1'b0, busy: 1'b0, drv: 1'b1, sda: 1'b1, scl: 1'b1};
  localparam line_result_t LINES_START =
    '{am: 1'b0, rx: 8'h00, done: 1'b0, busy: 1'b1, drv: 1'b1, sda: 1'b1, scl: 1'b1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  always #2 clk = ~clk;

  i2c_bit_level_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Line sequencer mirror.
  logic [7:0] bit_dly = i2cbm_pkg::BIT_DELAY_RST;
  logic [7:0] stop_hold = i2cbm_pkg::STOP_HOLD_RST;
  logic [7:0] ack_tmo = i2cbm_pkg::ACK_TMO_RST;
  logic [2:0] cur_cmd = i2cbm_pkg::CMD_IDLE;
  logic [3:0] seq_phase = '0;
  logic [3:0] bit_cnt = '0;
  logic [7:0] dly = '0;
  logic [7:0] polls = '0;
  logic [7:0] shreg = '0;
  logic       rd_ack = 1'b0;
  logic       scl_q = 1'b1;
  logic       sda_q = 1'b1;
  logic       drv_q = 1'b1;
  logic       nack_flag = 1'b0;
  logic [7:0] rx_hold = '0;

  pending_t pending_lines[$];
  script_row_t script [SCRIPT_LEN];
  int  fail_count = 0;
  int  items_sent = 0;
  int  cycles = 0;
  bit  steady = 1'b0;

  function automatic void load_delay(input logic [7:0] t);
    dly = (t == 8'd0) ? 8'd1 : t;
  endfunction

  function automatic void shift_out_bit();
    scl_q = 1'b0;
    sda_q = shreg[7];
    shreg = shreg << 1;
    load_delay(bit_dly);
    seq_phase = 4'd1;
  endfunction

  // Edges that follow an expired delay or a poll; returns 1 when the command ends.
  function automatic bit line_advance(input logic sda);
    case (cur_cmd)
      i2cbm_pkg::CMD_START: begin
        if (seq_phase == 4'd1) begin
          sda_q = 1'b1; load_delay(bit_dly); seq_phase = 4'd2; return 1'b0;
        end
        if (seq_phase == 4'd2) begin
          sda_q = 1'b0; load_delay(bit_dly); seq_phase = 4'd3; return 1'b0;
        end
        scl_q = 1'b0;
        return 1'b1;
      end
      i2cbm_pkg::CMD_STOP: begin
        if (seq_phase == 4'd1) begin
          scl_q = 1'b1; load_delay(stop_hold); seq_phase = 4'd2; return 1'b0;
        end
        sda_q = 1'b1;
        return 1'b1;
      end
      i2cbm_pkg::CMD_WRITE: begin
        if (seq_phase == 4'd1) begin
          scl_q = 1'b1; load_delay(bit_dly); seq_phase = 4'd2; return 1'b0;
        end
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          scl_q = 1'b0;
          return 1'b1;
        end
        shift_out_bit();
        return 1'b0;
      end
      i2cbm_pkg::CMD_WAITACK: begin
        if (seq_phase == 4'd1) begin
          scl_q = 1'b1; load_delay(bit_dly); seq_phase = 4'd2; return 1'b0;
        end
        if (seq_phase == 4'd2) begin
          if (!sda) begin
            scl_q = 1'b0;
            return 1'b1;
          end
          // Out of patience: fall into a stop sequence.
          if (polls >= ack_tmo) begin
            drv_q = 1'b1; sda_q = 1'b0; scl_q = 1'b0;
            load_delay(bit_dly);
            seq_phase = 4'd3;
            return 1'b0;
          end
          polls = polls + 8'd1;
          return 1'b0;
        end
        if (seq_phase == 4'd3) begin
          scl_q = 1'b1; load_delay(stop_hold); seq_phase = 4'd4; return 1'b0;
        end
        sda_q = 1'b1;
        nack_flag = 1'b1;
        return 1'b1;
      end
      i2cbm_pkg::CMD_READ: begin
        if (seq_phase == 4'd1) begin
          scl_q = 1'b1;
          shreg = {shreg[6:0], sda};
          load_delay(bit_dly);
          seq_phase = 4'd2;
          return 1'b0;
        end
        if (seq_phase == 4'd2) begin
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt < 4'd8) begin
            scl_q = 1'b0; load_delay(bit_dly); seq_phase = 4'd1; return 1'b0;
          end
          rx_hold = shreg;
          scl_q = 1'b0;
          drv_q = 1'b1;
          sda_q = ~rd_ack;
          load_delay(bit_dly);
          seq_phase = 4'd3;
          return 1'b0;
        end
        if (seq_phase == 4'd3) begin
          scl_q = 1'b1; load_delay(bit_dly); seq_phase = 4'd4; return 1'b0;
        end
        scl_q = 1'b0;
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic line_result_t predict_lines(input logic kind, input logic [2:0] cmd,
                                                 input logic [7:0] tx, input logic ack,
                                                 input logic sda);
    bit done;
    line_result_t r;
    done = 1'b0;
    if (kind == i2cbm_pkg::KIND_COMMAND) begin
      if (cur_cmd == i2cbm_pkg::CMD_IDLE && cmd <= i2cbm_pkg::CMD_READ) begin
        cur_cmd = cmd;
        bit_cnt = '0;
        polls = '0;
        case (cmd)
          i2cbm_pkg::CMD_START: begin
            drv_q = 1'b1; scl_q = 1'b1; load_delay(bit_dly); seq_phase = 4'd1;
          end
          i2cbm_pkg::CMD_STOP: begin
            drv_q = 1'b1; sda_q = 1'b0; scl_q = 1'b0;
            load_delay(bit_dly); seq_phase = 4'd1;
          end
          i2cbm_pkg::CMD_WRITE: begin
            drv_q = 1'b1; shreg = tx; shift_out_bit();
          end
          i2cbm_pkg::CMD_WAITACK: begin
            drv_q = 1'b0; sda_q = 1'b1; nack_flag = 1'b0;
            load_delay(bit_dly); seq_phase = 4'd1;
          end
          default: begin
            drv_q = 1'b0; rd_ack = ack; shreg = '0; scl_q = 1'b0;
            load_delay(bit_dly); seq_phase = 4'd1;
          end
        endcase
      end
    end else if (cur_cmd != i2cbm_pkg::CMD_IDLE) begin
      // While polling for the acknowledge every tick samples SDA.
      if (cur_cmd == i2cbm_pkg::CMD_WAITACK && seq_phase == 4'd2) begin
        done = line_advance(sda);
      end else begin
        if (dly != 8'd0) dly = dly - 8'd1;
        if (dly == 8'd0) done = line_advance(sda);
      end
      if (done) begin
        cur_cmd = i2cbm_pkg::CMD_IDLE;
        seq_phase = '0;
        dly = '0;
      end
    end
    r.scl  = scl_q;
    r.sda  = sda_q;
    r.drv  = drv_q;
    r.busy = (cur_cmd != i2cbm_pkg::CMD_IDLE);
    r.done = done;
    r.rx   = rx_hold;
    r.am   = nack_flag;
    return r;
  endfunction

  task automatic send_item(input logic kind, input logic [2:0] cmd, input logic [7:0] tx,
                           input logic ack, input logic sda,
                           input bit pin = 1'b0, input line_result_t pinned = '0);
    int gap;
    line_result_t want;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, sda, ack, tx, cmd};
    do @(posedge clk); while (!in_tready);
    want = predict_lines(kind, cmd, tx, ack, sda);
    pending_lines.push_back('{res: pin ? pinned : want, accept_ns: $realtime});
    items_sent++;
  endtask

  task automatic send_tick(input logic sda);
    send_item(i2cbm_pkg::KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
              sda);
  endtask

  // Stop sending and wait until every result transfer has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_lines.size() != 0);
  endtask

  task automatic quiesce();
    wait_drained();
    repeat (2) @(posedge clk);
  endtask

  task automatic finish_command(input run_mode_t mode, input bit noisy);
    logic sda;
    while (mode != RUN_NONE && cur_cmd != i2cbm_pkg::CMD_IDLE) begin
      case (mode)
        RUN_LOW:    sda = 1'b0;
        RUN_HIGH:   sda = 1'b1;
        RUN_MIX:    sda = ($urandom_range(0, 3) != 0);
        default:    sda = 1'($urandom);
      endcase
      if (noisy && $urandom_range(0, 15) == 0) begin
        // A command in the middle of a sequence must be dropped.
        send_item(i2cbm_pkg::KIND_COMMAND, 3'($urandom_range(0, 7)), 8'($urandom),
                  1'($urandom), 1'($urandom));
      end else begin
        send_tick(sda);
      end
      if (noisy && $urandom_range(0, 80) == 0) wait_drained();
    end
  endtask

  task automatic run_command(input logic [2:0] cmd, input run_mode_t mode);
    send_item(i2cbm_pkg::KIND_COMMAND, cmd, 8'($urandom), 1'($urandom), 1'($urandom));
    finish_command(mode, 1'b1);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      i2cbm_pkg::REG_BIT_DELAY: bit_dly = val;
      i2cbm_pkg::REG_STOP_HOLD: stop_hold = val;
      i2cbm_pkg::REG_ACK_TMO:   ack_tmo = val;
      default: ;
    endcase
  endtask

  task automatic program_timing(input logic [7:0] bd, input logic [7:0] sh,
                                input logic [7:0] at);
    write_reg(i2cbm_pkg::REG_BIT_DELAY, bd);
    write_reg(i2cbm_pkg::REG_STOP_HOLD, sh);
    write_reg(i2cbm_pkg::REG_ACK_TMO, at);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_transaction();
    steady = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 7) == 0) begin
      // Loose items: idle ticks, undefined codes, stray commands.
      repeat ($urandom_range(1, 6)) begin
        send_item(1'($urandom), 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                  1'($urandom));
        finish_command(RUN_RANDOM, 1'b1);
      end
    end else begin
      run_command(i2cbm_pkg::CMD_START, RUN_RANDOM);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 2) != 0) begin
          run_command(i2cbm_pkg::CMD_WRITE, RUN_RANDOM);
          run_command(i2cbm_pkg::CMD_WAITACK, RUN_MIX);
        end else begin
          run_command(i2cbm_pkg::CMD_READ, RUN_RANDOM);
        end
      end
      // Now and then the frame is left without its stop condition.
      if ($urandom_range(0, 5) != 0) run_command(i2cbm_pkg::CMD_STOP, RUN_RANDOM);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("i2c_bit_level_master test failed");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    pending_t     head;
    line_result_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[13:0];
      // An entry pushed on this very edge cannot have produced a result yet.
      if (pending_lines.size() == 0 || pending_lines[0].accept_ns >= $realtime) begin
        $error("result transfer with no item outstanding: %h", out_tdata);
        fail_count++;
      end else begin
        head = pending_lines.pop_front();
        if (seen.scl !== head.res.scl) begin
          $error("scl_level: expected %0d, got %0d", head.res.scl, seen.scl);
          fail_count++;
        end
        if (seen.sda !== head.res.sda) begin
          $error("sda_level: expected %0d, got %0d", head.res.sda, seen.sda);
          fail_count++;
        end
        if (seen.drv !== head.res.drv) begin
          $error("sda_drive: expected %0d, got %0d", head.res.drv, seen.drv);
          fail_count++;
        end
        if (seen.busy !== head.res.busy) begin
          $error("busy_res: expected %0d, got %0d", head.res.busy, seen.busy);
          fail_count++;
        end
        if (seen.done !== head.res.done) begin
          $error("done_res: expected %0d, got %0d", head.res.done, seen.done);
          fail_count++;
        end
        if (seen.rx !== head.res.rx) begin
          $error("rx_byte: expected %h, got %h", head.res.rx, seen.rx);
          fail_count++;
        end
        if (seen.am !== head.res.am) begin
          $error("ack_missing: expected %0d, got %0d", head.res.am, seen.am);
          fail_count++;
        end
        if (out_tdata[15:14] !== 2'b00) begin
          $error("padding: expected 0, got %b", out_tdata[15:14]);
          fail_count++;
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    int round_mark;
    script = '{
      '{i2cbm_pkg::KIND_TICK, i2cbm_pkg::CMD_START, 8'h00, 1'b0, 1'b0,
        RUN_NONE, 1'b1, LINES_IDLE},
      '{i2cbm_pkg::KIND_TICK, i2cbm_pkg::CMD_IDLE, 8'hFF, 1'b1, 1'b1,
        RUN_NONE, 1'b1, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, CMD_UNDEF_LO, 8'hAA, 1'b1, 1'b1,
        RUN_NONE, 1'b1, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, CMD_UNDEF_MID, 8'h55, 1'b0, 1'b0,
        RUN_NONE, 1'b1, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_IDLE, 8'hFF, 1'b1, 1'b0,
        RUN_NONE, 1'b1, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_START, 8'h00, 1'b0, 1'b0,
        RUN_NONE, 1'b1, LINES_START},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_STOP, 8'hFF, 1'b1, 1'b1,
        RUN_NONE, 1'b1, LINES_START},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_READ, 8'h0F, 1'b1, 1'b0,
        RUN_RANDOM, 1'b1, LINES_START},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b1,
        RUN_RANDOM, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_WAITACK, 8'h00, 1'b0, 1'b0,
        RUN_LOW, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0,
        RUN_RANDOM, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_WAITACK, 8'hF0, 1'b1, 1'b1,
        RUN_MIX, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_START, 8'h3C, 1'b0, 1'b1,
        RUN_RANDOM, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0,
        RUN_RANDOM, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_WAITACK, 8'h5A, 1'b0, 1'b1,
        RUN_LOW, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_READ, 8'h00, 1'b1, 1'b1,
        RUN_RANDOM, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_READ, 8'hFF, 1'b0, 1'b0,
        RUN_RANDOM, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_COMMAND, i2cbm_pkg::CMD_STOP, 8'h81, 1'b0, 1'b1,
        RUN_RANDOM, 1'b0, LINES_IDLE},
      '{i2cbm_pkg::KIND_TICK, i2cbm_pkg::CMD_WRITE, 8'h7E, 1'b1, 1'b0,
        RUN_NONE, 1'b0, LINES_IDLE}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script under the reset timing.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_item(script[i].kind, script[i].cmd, script[i].tx, script[i].ack, script[i].sda,
                script[i].pin, script[i].want);
      finish_command(script[i].after, 1'b0);
    end

    // Zero delays count as one tick; a zero timeout gives up on the first high poll.
    quiesce();
    write_reg(REG_UNUSED, 8'hFF);
    program_timing(8'd0, 8'd0, 8'd0);
    run_command(i2cbm_pkg::CMD_START, RUN_RANDOM);
    run_command(i2cbm_pkg::CMD_WRITE, RUN_RANDOM);
    run_command(i2cbm_pkg::CMD_WAITACK, RUN_HIGH);
    run_command(i2cbm_pkg::CMD_READ, RUN_RANDOM);
    run_command(i2cbm_pkg::CMD_WAITACK, RUN_LOW);
    run_command(i2cbm_pkg::CMD_STOP, RUN_RANDOM);

    quiesce();
    write_reg(REG_UNUSED, 8'h00);
    program_timing(8'd9, 8'd1, 8'd1);
    steady = 1'b1;
    run_command(i2cbm_pkg::CMD_START, RUN_RANDOM);
    steady = 1'b0;
    run_command(i2cbm_pkg::CMD_WAITACK, RUN_HIGH);

    quiesce();
    program_timing(8'd1, 8'd12, 8'd12);
    run_command(i2cbm_pkg::CMD_STOP, RUN_RANDOM);
    run_command(i2cbm_pkg::CMD_WAITACK, RUN_HIGH);

    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      quiesce();
      program_timing(($urandom_range(0, 7) == 0) ? 8'($urandom_range(2, 5))
                                                  : 8'($urandom_range(0, 1)),
                     8'($urandom_range(0, 4)), 8'($urandom_range(0, 6)));
      round_mark = items_sent;
      while (items_sent - round_mark < ROUND_ITEMS) random_transaction();
    end

    steady = 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (pending_lines.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("i2c_bit_level_master test passed");
    end else begin
      $display("i2c_bit_level_master test failed");
    end
    $finish;
  end

endmodule
